### src/pfs_pkg.sv
// Shared constants, types and the texture table of the perspective floor scroller.
package pfs_pkg;

	localparam int TEX_DEPTH  = 1024;
	localparam int TEX_ADDR_W = $clog2(TEX_DEPTH);
	localparam int OFFSET_W   = 18;
	localparam int STEP_W     = 19;
	localparam int TIME_W     = 20;
	localparam int HEIGHT_W   = 16;
	localparam int PIX_W      = 8;
	localparam int DIM_W      = 8;
	localparam int YOFF_W     = 9;
	localparam int NUM_W      = 21;
	localparam int DEN_W      = DIM_W + YOFF_W;
	localparam int DIV_CNT_W  = $clog2(NUM_W);

	localparam logic [PIX_W-1:0] SKY_VALUE = 8'h11;

	localparam logic CFG_SCREEN_WIDTH  = 1'b0;
	localparam logic CFG_SCREEN_HEIGHT = 1'b1;

	localparam logic [DIM_W-1:0] WIDTH_RESET  = 8'd80;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 8'd50;

	// texel codes as drawn in the table below
	localparam logic [7:0] CH_DARK  = 8'h6F; // 'o'
	localparam logic [7:0] CH_MID   = 8'h78; // 'x'
	localparam logic [7:0] CH_LIGHT = 8'h58; // 'X'

	typedef struct packed {
		logic              start;
		logic [NUM_W-1:0]  num;
		logic [DEN_W-1:0]  den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [STEP_W-1:0] quot;
	} div_rsp_t;

	localparam logic [255:0] TEX_ROWS [32] = '{
		{"........", "........", "........", "........"},
		{"........", "........", "..oooooo", "o......."},
		{"........", "........", "..oXxxxx", "o......."},
		{"........", "........", "..oXXxxx", "oo......"},
		{"........", "........", "..ooooox", "oo......"},
		{".......o", "oooooooo", "oo....oo", "o......."},
		{"...ooooo", "XXxxxXXx", "xo......", "........"},
		{".oooxXoo", "xXXxXXxo", "oooooooo", "oooooo.."},
		{".oxxXXoo", "ooooooXX", "XxxxxXXX", "XxoxXo.."},
		{".oooooo.", "..oooxxX", "XxxxxxXo", "oooooo.."},
		{"........", "..oxXXXx", "xxXXoooo", "........"},
		{".....ooo", "oooxxXXx", "xxxXoooo", "ooo....."},
		{"o...ooXX", "xXXXxooo", "XXXxxXXX", "oXoooooo"},
		{"o..ooxXX", "xxXXXo.o", "oXxxxxXX", "XXooxXXo"},
		{"o..oXXxx", "XXoooo..", "oooXXxxx", "xxxoooxx"},
		{"o..oXXxx", "XXoooooo", "oo.XXXxx", "Xooo.ooo"},
		{"...ooooo", "xxXXxxXX", "oooooooo", "oo......"},
		{"....oooo", "XXXXxxXX", "XXxXoooo", "o......."},
		{".ooooxxo", "ooooXXxx", "xXXXxXXx", "ooo....."},
		{"oooXXxxX", "XxxxXXxX", "XxxxXXXX", "xxooo..."},
		{"oxxXXxxX", "XxxxxxXX", "XxXoxxxx", "XXXxoo.."},
		{"oxxxxXXx", "xXXxxXXx", "XXXooxxX", "XXXxXo.."},
		{"ooooxXXx", "XXXXXxxx", "XXoooooo", "oooooooo"},
		{"xxxxxxxx", "XXXXXooo", "ooo.....", ".oxxXXXo"},
		{"oooooooo", "oooooo..", "........", ".ooooooo"},
		{"...ooooo", "........", "oooooooo", "oo......"},
		{"...oxXXo", "ooooo...", "oxooxxxx", "xooooo.."},
		{"...oXXoo", "oxxXo...", "ooooooox", "xxXXXo.."},
		{"...oooo.", "ooxXoooo", "......oo", "oooooo.."},
		{"........", ".ooxXoXo", "oo......", "........"},
		{"........", "..oooooo", "xo......", "........"},
		{"........", ".......o", "oo......", "........"}
	};

	function automatic logic [PIX_W-1:0] tex_value(input logic [TEX_ADDR_W-1:0] addr);
		logic [255:0] row;
		logic [7:0]   ch;
		logic [PIX_W-1:0] val;
		row = TEX_ROWS[addr[9:5]];
		ch  = row[(31 - addr[4:0]) * 8 +: 8];
		case (ch)
			CH_DARK:  val = 8'h02;
			CH_MID:   val = 8'h8A;
			CH_LIGHT: val = 8'hAA;
			default:  val = 8'h00;
		endcase
		return val;
	endfunction

endpackage

### src/pfs_in_if.sv
// Request channel: frame time and horizon height for the next pixel.
interface pfs_in_if;
	import pfs_pkg::*;

	logic                       valid;
	logic                       ready;
	logic [TIME_W-1:0]          frame_time;
	logic signed [HEIGHT_W-1:0] horizon_height;

	modport source(output valid, frame_time, horizon_height, input ready);
	modport sink(input valid, frame_time, horizon_height, output ready);
endinterface

### src/pfs_out_if.sv
// Pixel channel: colour byte with row and frame end marks.
interface pfs_out_if;
	import pfs_pkg::*;

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] pixel_value;
	logic             end_of_row;
	logic             end_of_frame;

	modport source(output valid, pixel_value, end_of_row, end_of_frame, input ready);
	modport sink(input valid, pixel_value, end_of_row, end_of_frame, output ready);
endinterface

### src/perspective_floor_scroller_top.sv
// Top level of the perspective floor scroller: counters, row set-up and pixel path.
// Path: a sky pixel or a floor pixel past column 0 passes the texture ROM read, then the
// output register; the first pixel of a floor row waits for the division first.
// Throughput: one item per cycle unless the output stalls; the first pixel of each
// floor row holds the input while the divider forms the row step, 21 bits serially.
// Reset: counters, latches, offset and step clear; width 80 and height 50; the texture
// ROM is fixed and needs no clearing pass.
module perspective_floor_scroller_top (
	input  logic                       clk,
	input  logic                       arst_n,
	pfs_in_if.sink                     req_ch,
	pfs_out_if.source                  pix_ch,
	input  logic                       wr_en,
	input  logic                       wr_index,
	input  logic [pfs_pkg::DIM_W-1:0]  wr_data
);
	import pfs_pkg::*;

	localparam logic [1:0] ST_RUN   = 2'd0;
	localparam logic [1:0] ST_DIV   = 2'd1;
	localparam logic [1:0] ST_ISSUE = 2'd2;

	// configuration
	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;

	// frame state
	logic [1:0]          state_q;
	logic [DIM_W-1:0]    row_q;
	logic [DIM_W-1:0]    col_q;
	logic [OFFSET_W-1:0] acc_q;
	logic [STEP_W-1:0]   step_q;
	logic [DIM_W-1:0]    lh_q;
	logic [TIME_W-1:0]   time_q;
	logic                pend_eor_q;
	logic                pend_eof_q;

	// ROM stage and output register
	logic             s2_valid_q;
	logic             sky_s2;
	logic             eor_s2;
	logic             eof_s2;
	logic             out_valid_q;
	logic [PIX_W-1:0] out_pixel_q;
	logic             out_eor_q;
	logic             out_eof_q;

	logic [DIM_W-1:0]      w_eff;
	logic [DIM_W-1:0]      h_eff;
	logic                  frame_start;
	logic [HEIGHT_W-1:0]   hv;
	logic [DIM_W-1:0]      lh_clamp;
	logic [DIM_W-1:0]      lh_new;
	logic [TIME_W-1:0]     time_new;
	logic signed [9:0]     sky_rows;
	logic                  is_floor;
	logic [9:0]            y_full;
	logic                  eor_c;
	logic                  eof_c;
	logic                  row_start;
	logic                  in_fire;
	logic                  s2_move;
	logic                  s2_can_load;
	logic                  s2_load;
	logic                  load_sky;
	logic                  load_eor;
	logic                  load_eof;
	logic [OFFSET_W-1:0]   acc_run;
	logic [OFFSET_W-1:0]   start_off;
	logic [OFFSET_W-1:0]   acc_start;
	logic [TEX_ADDR_W-1:0] rom_addr;
	logic [PIX_W-1:0]      rom_data;
	div_req_t              div_req;
	div_rsp_t              div_rsp;

	// a zero register reads as one
	assign w_eff = (width_q  == '0) ? DIM_W'(1) : width_q;
	assign h_eff = (height_q == '0) ? DIM_W'(1) : height_q;

	// latch time and clamped horizon on the first pixel of a frame
	assign frame_start = (row_q == '0) && (col_q == '0);
	assign hv          = req_ch.horizon_height;
	always_comb begin
		if (hv[HEIGHT_W-1]) begin
			lh_clamp = '0;
		end else if (hv > {8'h00, h_eff - 8'd1}) begin
			lh_clamp = h_eff - 8'd1;
		end else begin
			lh_clamp = hv[DIM_W-1:0];
		end
	end
	assign lh_new   = frame_start ? lh_clamp : lh_q;
	assign time_new = frame_start ? req_ch.frame_time : time_q;

	// sky rows may go negative if the height register shrank mid-frame
	assign sky_rows = $signed({2'b00, h_eff}) - $signed({2'b00, lh_new});
	assign is_floor = $signed({2'b00, row_q}) >= sky_rows;
	assign y_full   = {2'b00, row_q} - sky_rows + 10'd3;

	assign eor_c     = ({1'b0, col_q} + 9'd1) >= {1'b0, w_eff};
	assign eof_c     = eor_c && (({1'b0, row_q} + 9'd1) >= {1'b0, h_eff});
	assign row_start = is_floor && (col_q == '0);

	// handshake: the ROM stage drains into the output register
	assign s2_move      = s2_valid_q && (!out_valid_q || pix_ch.ready);
	assign s2_can_load  = !s2_valid_q || s2_move;
	assign req_ch.ready = (state_q == ST_RUN) && s2_can_load;
	assign in_fire      = req_ch.valid && req_ch.ready;

	// step = (h*5120/w)/(y+3) = h*5120 / (w*(y+3)): one division does it
	assign div_req.start = in_fire && row_start;
	assign div_req.num   = {lh_new, 12'd0} + {2'b00, lh_new, 10'd0} + NUM_W'(0);
	assign div_req.den   = DEN_W'(w_eff) * DEN_W'(y_full[YOFF_W-1:0]);

	pfs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// row start offset: t*32 - s*20 - (s>>4)*8192, modulo the accumulator
	assign acc_run   = acc_q + step_q[OFFSET_W-1:0];
	assign start_off = {time_q[12:0], 5'd0}
		- {div_rsp.quot[13:0], 4'd0}
		- {div_rsp.quot[15:0], 2'd0}
		- {div_rsp.quot[8:4], 13'd0};
	assign acc_start = start_off + div_rsp.quot[OFFSET_W-1:0];

	// pick what enters the ROM stage this cycle
	always_comb begin
		s2_load  = 1'b0;
		load_sky = 1'b0;
		load_eor = eor_c;
		load_eof = eof_c;
		rom_addr = acc_run[OFFSET_W-1:OFFSET_W-TEX_ADDR_W];
		case (state_q)
			ST_RUN: begin
				s2_load  = in_fire && !row_start;
				load_sky = !is_floor;
			end
			ST_ISSUE: begin
				s2_load  = s2_can_load;
				load_eor = pend_eor_q;
				load_eof = pend_eof_q;
				rom_addr = acc_start[OFFSET_W-1:OFFSET_W-TEX_ADDR_W];
			end
			default: begin
				s2_load = 1'b0;
			end
		endcase
	end

	pfs_tex_rom u_rom (
		.clk     (clk),
		.rd_en   (s2_load),
		.rd_addr (rom_addr),
		.rd_data (rom_data)
	);

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				CFG_SCREEN_WIDTH:  width_q  <= wr_data;
				CFG_SCREEN_HEIGHT: height_q <= wr_data;
				default: begin
					width_q <= width_q;
				end
			endcase
		end
	end

	// counters, latches, offset and the row set-up sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_RUN;
			row_q      <= '0;
			col_q      <= '0;
			acc_q      <= '0;
			step_q     <= '0;
			lh_q       <= '0;
			time_q     <= '0;
			pend_eor_q <= 1'b0;
			pend_eof_q <= 1'b0;
		end else begin
			case (state_q)
				ST_RUN: begin
					if (in_fire) begin
						lh_q   <= lh_new;
						time_q <= time_new;
						if (eor_c) begin
							col_q <= '0;
							row_q <= eof_c ? '0 : row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
						if (row_start) begin
							state_q    <= ST_DIV;
							pend_eor_q <= eor_c;
							pend_eof_q <= eof_c;
						end else if (is_floor) begin
							acc_q <= acc_run;
						end
					end
				end
				ST_DIV: begin
					if (div_rsp.done) begin
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: begin
					if (s2_can_load) begin
						state_q <= ST_RUN;
						acc_q   <= acc_start;
						step_q  <= div_rsp.quot;
					end
				end
				default: begin
					state_q <= ST_RUN;
				end
			endcase
		end
	end

	// ROM stage flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (s2_load) begin
			s2_valid_q <= 1'b1;
		end else if (s2_move) begin
			s2_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load) begin
			sky_s2 <= load_sky;
			eor_s2 <= load_eor;
			eof_s2 <= load_eof;
		end
	end

	// output register: hold while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_move) begin
			out_valid_q <= 1'b1;
		end else if (pix_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			out_pixel_q <= sky_s2 ? SKY_VALUE : rom_data;
			out_eor_q   <= eor_s2;
			out_eof_q   <= eof_s2;
		end
	end

	assign pix_ch.valid        = out_valid_q;
	assign pix_ch.pixel_value  = out_pixel_q;
	assign pix_ch.end_of_row   = out_eor_q;
	assign pix_ch.end_of_frame = out_eof_q;

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && eof_c) |=> (row_q == '0 && col_q == '0))
		else $error("counters did not wrap at end of frame");
	a_height_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && frame_start) |=> (lh_q < $past(h_eff)))
		else $error("latched height beyond frame height");
	a_div_to_issue: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && div_rsp.done) |=> (state_q == ST_ISSUE))
		else $error("row step lost after division");
endmodule

### src/pfs_tex_rom.sv
// Texture ROM, 1024 x 8, registered read.
module pfs_tex_rom (
	input  logic                           clk,
	input  logic                           rd_en,
	input  logic [pfs_pkg::TEX_ADDR_W-1:0] rd_addr,
	output logic [pfs_pkg::PIX_W-1:0]      rd_data
);
	import pfs_pkg::*;

	logic [PIX_W-1:0] data_q;

	// hold the last word while no read is issued
	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_q <= tex_value(rd_addr);
		end
	end

	assign rd_data = data_q;
endmodule

### src/pfs_div.sv
// Restoring divider, one quotient bit per cycle, for the row step.
module pfs_div (
	input  logic              clk,
	input  logic              arst_n,
	input  pfs_pkg::div_req_t req,
	output pfs_pkg::div_rsp_t rsp
);
	import pfs_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0]     rem_q;
	logic [DEN_W-1:0]     den_q;
	logic [NUM_W-1:0]     num_q;
	logic [DEN_W:0]       trial;
	logic                 take;

	assign trial = {rem_q, num_q[NUM_W-1]};
	assign take  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// num_q shifts the dividend out and the quotient in
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			num_q <= {num_q[NUM_W-2:0], take};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q[STEP_W-1:0];

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |=> busy_q)
		else $error("divider did not start");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q)
		else $error("divider done while still busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("divider done held for more than one cycle");
endmodule
